[src/swm_pkg.sv]
// Shared constants, types and helper functions of the sliding window median filter.
package swm_pkg;

  localparam int unsigned WINDOW_MAX = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RES_W      = DATA_W + 1;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SIZE_RESET = 3;

  typedef logic signed [DATA_W-1:0] swm_word_t;
  typedef swm_word_t [WINDOW_MAX-1:0] swm_win_t;

  // One-hot selects of the two middle positions of the sorted window.
  typedef struct packed {
    logic [WINDOW_MAX-1:0] lo_sel;
    logic [WINDOW_MAX-1:0] hi_sel;
  } swm_mid_sel_t;

  // Clamp a written window size to 1..WINDOW_MAX.
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    int unsigned w;
    w = int'(v);
    if (w == 0) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    return CNT_W'(w);
  endfunction

  // Positions (k-1)/2 and k/2 as one-hot masks.
  function automatic swm_mid_sel_t mid_sel(input logic [CNT_W-1:0] k);
    swm_mid_sel_t s;
    logic [CNT_W-1:0] lo_pos;
    logic [CNT_W-1:0] hi_pos;
    lo_pos = (k - CNT_W'(1)) >> 1;
    hi_pos = k >> 1;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      s.lo_sel[i] = (CNT_W'(i) == lo_pos);
      s.hi_sel[i] = (CNT_W'(i) == hi_pos);
    end
    return s;
  endfunction

endpackage

[src/swm_window.sv]
// Window state: size register, arrival line and sorted multiset, updated on each accepted sample.
module swm_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [swm_pkg::DATA_W-1:0]    sample_i,
  input  logic                          first_of_sequence_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output swm_pkg::swm_win_t             sorted_o,
  output swm_pkg::swm_mid_sel_t         sel_o
);
  import swm_pkg::*;

  logic [CNT_W-1:0]  ksz_q, ksz_d;
  swm_mid_sel_t      sel_q, sel_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              pend_q, pend_d;
  swm_win_t          sorted_q, sorted_d;
  swm_win_t          arr_q, arr_d;

  logic              accept;
  logic [CNT_W-1:0]  fe;
  logic [CNT_W-1:0]  ins_n;
  logic [CNT_W-1:0]  fill_nx;
  logic              full;
  logic              found;
  logic              hit;
  swm_word_t         old_w;
  swm_word_t         x;
  swm_win_t          s_up, rem, rem_dn, arr_up;
  logic [WINDOW_MAX-1:0] le, le_prev;

  assign x          = $signed(sample_i);
  assign in_stall_o = pend_q && !res_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fe      = (first_of_sequence_i || (fill_q > ksz_q)) ? '0 : fill_q;
    full    = (fe == ksz_q);
    old_w   = arr_q[0];
    s_up    = {sorted_q[WINDOW_MAX-1], sorted_q[WINDOW_MAX-1:1]};
    arr_up  = {arr_q[WINDOW_MAX-1], arr_q[WINDOW_MAX-1:1]};

    // drop the first instance of the oldest sample when the window is full
    found = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      hit    = full && (CNT_W'(i) < ksz_q) && (sorted_q[i] == old_w);
      found  = found || hit;
      rem[i] = found ? s_up[i] : sorted_q[i];
    end

    // insert after equal values: le is a run of ones up to the insert point
    ins_n  = full ? (ksz_q - CNT_W'(1)) : fe;
    rem_dn = {rem[WINDOW_MAX-2:0], rem[0]};
    for (int i = 0; i < WINDOW_MAX; i++) begin
      le[i] = (CNT_W'(i) < ins_n) && ($signed(rem[i]) <= x);
    end
    le_prev = {le[WINDOW_MAX-2:0], 1'b1};
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (le[i]) begin
        sorted_d[i] = rem[i];
      end else if (le_prev[i]) begin
        sorted_d[i] = x;
      end else begin
        sorted_d[i] = rem_dn[i];
      end
    end

    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (full) begin
        if (CNT_W'(i) == ksz_q - CNT_W'(1)) begin
          arr_d[i] = x;
        end else if (CNT_W'(i) < ksz_q - CNT_W'(1)) begin
          arr_d[i] = arr_up[i];
        end else begin
          arr_d[i] = arr_q[i];
        end
      end else begin
        arr_d[i] = (CNT_W'(i) == fe) ? x : arr_q[i];
      end
    end

    fill_nx = full ? ksz_q : (fe + CNT_W'(1));
  end

  always_comb begin
    ksz_d  = ksz_q;
    sel_d  = sel_q;
    fill_d = fill_q;
    pend_d = pend_q;
    if (cfg_we_i) begin
      ksz_d  = eff_size(cfg_wdata_i);
      sel_d  = mid_sel(eff_size(cfg_wdata_i));
      fill_d = '0;
    end else if (accept) begin
      fill_d = fill_nx;
    end
    if (accept) begin
      pend_d = (fill_nx == ksz_q);
    end else if (res_take_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksz_q  <= CNT_W'(SIZE_RESET);
      sel_q  <= mid_sel(CNT_W'(SIZE_RESET));
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      ksz_q  <= ksz_d;
      sel_q  <= sel_d;
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sorted_q <= sorted_d;
      arr_q    <= arr_d;
    end
  end

  assign res_valid_o = pend_q;
  assign sorted_o    = sorted_q;
  assign sel_o       = sel_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ksz_q)
    else $error("fill count beyond window size");
  a_pend_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (fill_q == ksz_q))
    else $error("result pending with a window that is not full");
  a_lo_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(sel_q.lo_sel))
    else $error("lower middle select not one-hot");
  a_hi_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(sel_q.hi_sel))
    else $error("upper middle select not one-hot");

endmodule

[src/swm_median.sv]
// Middle-pair select and add into the output register, with output handshake.
module swm_median (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  output logic                          res_take_o,
  input  swm_pkg::swm_win_t             sorted_i,
  input  swm_pkg::swm_mid_sel_t         sel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [swm_pkg::RES_W-1:0] median_x2_o
);
  import swm_pkg::*;

  logic                    out_valid_q, out_valid_d;
  logic signed [RES_W-1:0] median_q;
  logic                    adv;
  logic [DATA_W-1:0]       lo_w, hi_w;

  assign adv        = !out_valid_q || !out_stall_i;
  assign res_take_o = res_valid_i && adv;

  always_comb begin
    lo_w = '0;
    hi_w = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_w = lo_w | (sorted_i[i] & {DATA_W{sel_i.lo_sel[i]}});
      hi_w = hi_w | (sorted_i[i] & {DATA_W{sel_i.hi_sel[i]}});
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) out_valid_d = res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      median_q <= $signed({lo_w[DATA_W-1], lo_w}) + $signed({hi_w[DATA_W-1], hi_w});
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_x2_o = median_q;

endmodule

[src/sliding_window_median.sv]
// Top level of the sliding window median filter.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i/in_stall_o    sample_i, first_of_sequence_i
//   out      output     out_valid_o/out_stall_i  median_x2_o
//   cfg      input      cfg_we_i                 cfg_wdata_i (window_size)
//
// One sample per clock while in_stall_o is low: the window update (removal and
// insertion) is done in the cycle of the transaction; the median is then summed
// from the sorted window into the output register, which raises out_valid_o; a
// stalled output keeps the result pending in the window until it is taken.
// Reset empties the window and sets the window size to 3; no clearing pass.
// Input is held off only while a result waits behind a stalled output register.
module sliding_window_median (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [swm_pkg::DATA_W-1:0]    sample_i,
  input  logic                          first_of_sequence_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [swm_pkg::RES_W-1:0] median_x2_o
);
  import swm_pkg::*;

  logic         res_valid;
  logic         res_take;
  swm_win_t     sorted;
  swm_mid_sel_t sel;

  swm_window u_window (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .first_of_sequence_i (first_of_sequence_i),
    .res_valid_o         (res_valid),
    .res_take_i          (res_take),
    .sorted_o            (sorted),
    .sel_o               (sel)
  );

  swm_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_take_o  (res_take),
    .sorted_i    (sorted),
    .sel_i       (sel),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_x2_o (median_x2_o)
  );

endmodule

[sim/tb_top.sv]
// Testbench for the sliding window median filter, checked against a running-median predictor.
`timescale 1ns / 100ps

module tb_top;
  import swm_pkg::*;

  typedef logic signed [RES_W-1:0] median_t;
  typedef enum logic {ROW_SAMPLE, ROW_SIZE} row_kind_e;
  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] size;
    swm_word_t        smp;
    logic             fos;
    logic             typed;
    median_t          want;
  } dir_row_t;

  localparam int N_ROWS = 24;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    // reset size of three, largest then smallest sample
    '{ROW_SAMPLE, 6'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, 6'd0, 32'h8000_0000, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h8000_0000, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    // zero size behaves as one
    '{ROW_SIZE,   6'd0, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0005, 1'b0, 1'b1, 33'h0_0000_000A},
    '{ROW_SAMPLE, 6'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFE},
    '{ROW_SAMPLE, 6'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 33'h0_FFFF_FFFE},
    // even size: sum of both middle values
    '{ROW_SIZE,   6'd2, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h8000_0000, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFF},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0003, 1'b0, 1'b1, 33'h0_8000_0002},
    // repeated values in a window of five, then a cleared sequence
    '{ROW_SIZE,   6'd5, 32'h0,         1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'hFFFF_FFFC, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0009, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'hFFFF_FFFC, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'hFFFF_FFFC, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 6'd0, 32'h0000_0000, 1'b1, 1'b0, 33'h0}
  };

  localparam logic [CFG_W-1:0] EXTREME_SIZES [7] = '{6'd0, 6'd63, 6'd32, 6'd33, 6'd1, 6'd2,
                                                     6'd31};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [DATA_W-1:0] sample_i = '0;
  logic             first_of_sequence_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  median_t          median_x2_o;

  logic [CFG_W-1:0] window_size_r = CFG_W'(SIZE_RESET);
  swm_word_t        arrival_q[$];
  swm_word_t        sorted_q[$];
  median_t          median_q[$];
  median_t          want_med;
  int unsigned      items_sent = 0;
  int unsigned      mismatch_cnt = 0;
  bit               quiet = 1'b0;

  sliding_window_median dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .first_of_sequence_i (first_of_sequence_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .median_x2_o         (median_x2_o)
  );

  always #5 clk_i = ~clk_i;

  // Slide the window by one sample; returns 1 when the window is full.
  function automatic bit slide_window(input swm_word_t x, input bit fos, output median_t med);
    int unsigned k;
    int unsigned p;
    swm_word_t   oldest;
    median_t     lo;
    median_t     hi;
    k = (window_size_r == 0) ? 1 :
        ((window_size_r > WINDOW_MAX) ? WINDOW_MAX : int'(window_size_r));
    med = '0;
    if (fos) begin
      arrival_q.delete();
      sorted_q.delete();
    end
    if (arrival_q.size() >= k) begin
      oldest = arrival_q.pop_front();
      for (int j = 0; j < sorted_q.size(); j++) begin
        if (sorted_q[j] == oldest) begin
          sorted_q.delete(j);
          break;
        end
      end
    end
    arrival_q.insert(arrival_q.size(), x);
    // insert after any equal values
    p = 0;
    while (p < sorted_q.size() && sorted_q[p] <= x) p++;
    sorted_q.insert(p, x);
    if (arrival_q.size() != k) return 1'b0;
    lo = sorted_q[(k - 1) / 2];
    hi = sorted_q[k / 2];
    med = lo + hi;
    return 1'b1;
  endfunction

  function automatic swm_word_t random_sample();
    unique case ($urandom_range(0, 9))
      0: begin
        unique case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      // narrow range to crowd the window with repeats
      1, 2, 3: return swm_word_t'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_sample(input swm_word_t x, input bit fos, input bit typed,
                             input median_t want);
    median_t med;
    bit      has_med;
    in_valid_i          <= 1'b1;
    sample_i            <= x;
    first_of_sequence_i <= fos;
    // hold the payload until the transaction is taken
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    has_med = slide_window(x, fos, med);
    if (typed) median_q.insert(median_q.size(), want);
    else if (has_med) median_q.insert(median_q.size(), med);
    items_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic set_window_size(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    // drain results, then let the last silent sample settle
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_size_r = v;
    arrival_q.delete();
    sorted_q.delete();
  endtask

  initial begin
    dir_row_t         row;
    logic [CFG_W-1:0] sz;
    int unsigned      phase;
    int unsigned      n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_SIZE) set_window_size(row.size);
      else send_sample(row.smp, row.fos, row.typed, row.want);
    end
    phase = 0;
    while (items_sent < 1900) begin
      if (phase < 7) sz = EXTREME_SIZES[phase];
      else if ($urandom_range(0, 9) == 0) sz = CFG_W'($urandom_range(0, 63));
      else sz = CFG_W'($urandom_range(1, 8));
      if (items_sent > 1650) quiet = 1'b1;
      set_window_size(sz);
      n = (sz >= 16) ? 160 : 90;
      repeat (n) send_sample(random_sample(), $urandom_range(0, 59) == 0, 1'b0, '0);
      phase++;
    end
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Output stall in bursts, with calm stretches in between
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (median_q.size() == 0) begin
        $display("%0t: unexpected median_x2: expected none, actual %0d", $time, median_x2_o);
        mismatch_cnt++;
      end else begin
        want_med = median_q.pop_front();
        if (median_x2_o !== want_med) begin
          $display("%0t: median_x2 mismatch: expected %0d, actual %0d", $time, want_med,
                   median_x2_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
